// File: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, codes and the character classification used by the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depths of the two internal queues.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_BADPAD  = 2'd2,
        ST_BADLEN  = 2'd3
    } status_t;

    // Class of an incoming character.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [5:0] sextet;
        kind_t      kind;
        logic       last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last_out;
        status_t    status;
    } result_t;

    // Alphabet boundaries and special characters.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Map one character to its sextet and class.
    function automatic item_t classify(input logic [7:0] c, input logic last);
        item_t      it;
        logic [7:0] diff;
        begin
            it.sextet = '0;
            it.kind   = KIND_BAD;
            it.last   = last;
            diff      = '0;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                diff      = c - CH_UPPER_A;
                it.sextet = diff[5:0];
                it.kind   = KIND_DATA;
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                diff      = c - CH_LOWER_A + 8'd26;
                it.sextet = diff[5:0];
                it.kind   = KIND_DATA;
            end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                diff      = c - CH_DIGIT_0 + 8'd52;
                it.sextet = diff[5:0];
                it.kind   = KIND_DATA;
            end else if (c == CH_PLUS) begin
                it.sextet = SEXTET_PLUS;
                it.kind   = KIND_DATA;
            end else if (c == CH_SLASH) begin
                it.sextet = SEXTET_SLASH;
                it.kind   = KIND_DATA;
            end else if (c == CH_PAD) begin
                it.kind   = KIND_PAD;
            end
            return it;
        end
    endfunction

endpackage

// File: hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// Base64 decoder queue
// Small first-word-fall-through queue used between the decoder stages.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status flags and transfer qualifiers.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates; pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Takes in characters and classifies them into sextet, padding or invalid.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic            push,
    input  logic [7:0]      char_in,
    input  logic            last_in,
    output logic            item_push,
    output b64d_pkg::item_t item
);

    import b64d_pkg::*;

    // Alphabet lookup; the queue behind this stage qualifies the transfer.
    assign item      = classify(char_in, last_in);
    assign item_push = push;

endmodule

// File: hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Tracks quartet position, leftover bits, padding and sticky errors, and
// assembles one result for each classified character.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_empty,
    input  b64d_pkg::item_t   item,
    output logic              item_pop,
    input  logic              res_full,
    output logic              res_push,
    output b64d_pkg::result_t res
);

    import b64d_pkg::*;

    logic [5:0] carry_reg, carry_next;
    logic [1:0] pos_reg, pos_next;
    logic       pad_reg, pad_next;
    status_t    err_reg, err_next;
    logic       fire;
    logic [1:0] pos_inc;
    status_t    st;
    logic [7:0] byte_val;
    logic       valid;

    // A transfer happens whenever an item waits and the result queue has room.
    assign fire     = !item_empty && !res_full;
    assign item_pop = fire;
    assign res_push = fire;
    assign pos_inc  = pos_reg + 2'd1;

    // Decode one item and work out the next state.
    always_comb
    begin
        st         = err_reg;
        byte_val   = '0;
        valid      = 1'b0;
        carry_next = carry_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        if (err_reg == ST_OK) begin
            if (pad_reg) begin
                if (!(item.kind == KIND_PAD && pos_reg == 2'd3)) begin
                    st = ST_BADPAD;
                end
            end else if (item.kind == KIND_BAD) begin
                st = ST_BADCHAR;
            end else if (item.kind == KIND_PAD) begin
                if (pos_reg < 2'd2) begin
                    st = ST_BADPAD;
                end else begin
                    pad_next = 1'b1;
                end
            end else begin
                case (pos_reg)
                    2'd0:
                    begin
                        carry_next = item.sextet;
                    end
                    2'd1:
                    begin
                        byte_val   = {carry_reg, item.sextet[5:4]};
                        carry_next = {2'b00, item.sextet[3:0]};
                        valid      = 1'b1;
                    end
                    2'd2:
                    begin
                        byte_val   = {carry_reg[3:0], item.sextet[5:2]};
                        carry_next = {4'b0000, item.sextet[1:0]};
                        valid      = 1'b1;
                    end
                    default:
                    begin
                        byte_val   = {carry_reg[1:0], item.sextet};
                        carry_next = '0;
                        valid      = 1'b1;
                    end
                endcase
            end
            if (st == ST_OK) begin
                pos_next = pos_inc;
                if (item.last && pos_inc != 2'd0) begin
                    st = ST_BADLEN;
                end
            end
            if (st != ST_OK) begin
                err_next = st;
                valid    = 1'b0;
                byte_val = '0;
            end
        end
        // The final character of a stream returns everything to reset.
        if (item.last) begin
            carry_next = '0;
            pos_next   = '0;
            pad_next   = 1'b0;
            err_next   = ST_OK;
        end
    end

    assign res.byte_out   = byte_val;
    assign res.byte_valid = valid;
    assign res.last_out   = item.last;
    assign res.status     = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            carry_reg <= '0;
            pos_reg   <= '0;
            pad_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end else if (fire) begin
            carry_reg <= carry_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: hw/rtl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a stream of Base64 characters, one byte result per character.
//
// Usage: write one character with its last flag per transfer on the input
// side (push while full is low). Each character yields exactly one result on
// the output side, read with pop while empty is low: a decoded byte with a
// valid flag, the echoed last flag and a status code (ok, invalid character,
// misplaced padding, bad length). Errors stick until the last character.
// A character accepted at the input passes through the middle queue and
// the back end into the output queue, whose head drives the result ports.
// Throughput: one character per cycle while full is low; classification
// is combinational into the middle queue, and the quartet state update
// of the back end writes the output queue.
// When the receiver stalls, results fill the output queue, then the middle
// queue, and full rises; nothing is lost. Reset empties both queues and
// clears the quartet position, leftover bits, padding flag and error.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = b64d_pkg::MID_DEPTH,
    parameter int OUT_DEPTH   = b64d_pkg::OUT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       last_in,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] byte_out,
    output logic       byte_valid,
    output logic       last_out,
    output logic [1:0] status
);

    import b64d_pkg::*;

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);

    item_t   front_item;
    logic    front_push;
    item_t   mid_item;
    logic    mid_empty;
    logic    mid_pop;
    result_t back_res;
    logic    out_push;
    logic    out_full;
    result_t out_res;

    // Classification of incoming characters.
    b64d_front u_front (
        .push      (push),
        .char_in   (char_in),
        .last_in   (last_in),
        .item_push (front_push),
        .item      (front_item)
    );

    // Queue between the front end and the back end.
    b64d_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    // Quartet state and byte assembly.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_empty (mid_empty),
        .item       (mid_item),
        .item_pop   (mid_pop),
        .res_full   (out_full),
        .res_push   (out_push),
        .res        (back_res)
    );

    // Result queue towards the receiver.
    b64d_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign byte_out   = out_res.byte_out;
    assign byte_valid = out_res.byte_valid;
    assign last_out   = out_res.last_out;
    assign status     = out_res.status;

    // A result that reports an error never carries a byte.
    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (!byte_valid && byte_out == 8'h00))
        else $error("error result carries a byte");

    // The back end only writes a result when the output queue has room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result written into a full output queue");

    // A character entering an idle pipeline passes through the middle queue and the
    // back end into the output queue, where its result shows on the result ports.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && mid_empty && !out_full) |-> ##2 !empty)
        else $error("result did not appear after two cycles");

    // The back end consumes a classified item whenever it can deliver a result.
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (!mid_empty && !out_full) |=> !(empty && $past(mid_pop) == 1'b0))
        else $error("back end stalled with room in the output queue");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Drives encoded characters through the decoder's input queue interface and
// checks every result against a typed value or a cycle-free predictor. A short
// table of directed characters covers the alphabet extremes, padding and each
// error case; random streams, mostly well-formed with some broken or noisy
// ones, follow. Both sides idle in random bursts, and the receiver once holds
// off for a long stretch so that the decoder fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    import b64d_pkg::*;

    localparam int ITEM_TARGET    = 800;
    localparam int QUIET_TAIL     = 100;
    localparam int HOLD_AT        = 350;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Character classes as seen by the predictor.
    localparam logic [6:0] CODE_PAD = 7'd64;
    localparam logic [6:0] CODE_BAD = 7'd65;

    // Ways in which a random stream is damaged.
    typedef enum int {
        MUT_BADCHAR,
        MUT_EARLY_PAD,
        MUT_TRUNCATE,
        MUT_TRAILING
    } mutation_t;

    // One row of the directed stimulus table.
    typedef struct {
        logic [7:0] char_val;
        logic       last_val;
        logic       typed;
        result_t    typed_result;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] char_in;
    logic       last_in;
    logic       pop;
    logic       empty;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       last_out;
    logic [1:0] status;

    // Predictor state.
    logic [1:0] quad_pos;
    logic [5:0] leftover_bits;
    logic       pad_seen;
    status_t    first_error;

    result_t    pending_results[$];
    stim_row_t  directed_rows[$];
    int         sent_count;
    int         error_count;
    int         quiet_cycles;
    logic       quiet_phase;

    assign quiet_phase = (sent_count >= ITEM_TARGET - QUIET_TAIL);

    base64_stream_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_in    (char_in),
        .last_in    (last_in),
        .pop        (pop),
        .empty      (empty),
        .byte_out   (byte_out),
        .byte_valid (byte_valid),
        .last_out   (last_out),
        .status     (status)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Reset is held at the start of the run only.
    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Map a character to its sextet, or to the padding or invalid class.
    function automatic logic [6:0] char_code(input logic [7:0] c);
        logic [6:0] code;
        begin
            code = CODE_BAD;
            if (c >= "A" && c <= "Z")
                code = 7'(c - "A");
            else if (c >= "a" && c <= "z")
                code = 7'(c - "a" + 26);
            else if (c >= "0" && c <= "9")
                code = 7'(c - "0" + 52);
            else if (c == CH_PLUS)
                code = 7'd62;
            else if (c == CH_SLASH)
                code = 7'd63;
            else if (c == CH_PAD)
                code = CODE_PAD;
            return code;
        end
    endfunction

    // Alphabet character for a sextet, used to build well-formed streams.
    function automatic logic [7:0] data_char(input logic [5:0] s);
        logic [7:0] c;
        begin
            if (s < 26)
                c = 8'("A" + s);
            else if (s < 52)
                c = 8'("a" + s - 26);
            else if (s < 62)
                c = 8'("0" + s - 52);
            else if (s == 62)
                c = CH_PLUS;
            else
                c = CH_SLASH;
            return c;
        end
    endfunction

    // Advance the decoder state by one character and return its result.
    function automatic result_t decode_char(input logic [7:0] c, input logic l);
        result_t    res;
        logic [6:0] code;
        logic [5:0] s;
        logic [1:0] pos;
        logic [1:0] nxt;
        status_t    st;
        begin
            res  = '0;
            st   = first_error;
            pos  = quad_pos;
            nxt  = pos + 2'd1;
            code = char_code(c);
            s    = code[5:0];
            if (st == ST_OK)
            begin
                if (pad_seen)
                begin
                    // Only the second padding character at the last position may follow.
                    if (!(code == CODE_PAD && pos == 2'd3))
                        st = ST_BADPAD;
                end
                else if (code == CODE_BAD)
                    st = ST_BADCHAR;
                else if (code == CODE_PAD)
                begin
                    if (pos < 2'd2)
                        st = ST_BADPAD;
                    else
                        pad_seen = 1'b1;
                end
                else
                begin
                    // Pack the sextet with the leftover bits of the previous one.
                    case (pos)
                        2'd0:
                        begin
                            leftover_bits = s;
                        end
                        2'd1:
                        begin
                            res.byte_out   = {leftover_bits, s[5:4]};
                            leftover_bits  = {2'b00, s[3:0]};
                            res.byte_valid = 1'b1;
                        end
                        2'd2:
                        begin
                            res.byte_out   = {leftover_bits[3:0], s[5:2]};
                            leftover_bits  = {4'b0000, s[1:0]};
                            res.byte_valid = 1'b1;
                        end
                        default:
                        begin
                            res.byte_out   = {leftover_bits[1:0], s};
                            leftover_bits  = '0;
                            res.byte_valid = 1'b1;
                        end
                    endcase
                end
                if (st == ST_OK)
                begin
                    quad_pos = nxt;
                    if (l && nxt != 2'd0)
                        st = ST_BADLEN;
                end
                if (st != ST_OK)
                begin
                    first_error    = st;
                    res.byte_valid = 1'b0;
                    res.byte_out   = '0;
                end
            end
            res.last_out = l;
            res.status   = st;
            // The final character of a stream returns everything to reset.
            if (l)
            begin
                quad_pos      = '0;
                leftover_bits = '0;
                pad_seen      = 1'b0;
                first_error   = ST_OK;
            end
            return res;
        end
    endfunction

    // Offer one character until it is taken, then record what it should yield.
    task automatic send_char(input logic [7:0] c, input logic l,
                             input logic typed, input result_t typed_result);
        result_t predicted;
        begin
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            push    <= 1'b1;
            char_in <= c;
            last_in <= l;
            do
                @(posedge clk);
            while (full);
            predicted = decode_char(c, l);
            pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
            sent_count++;
        end
    endtask

    task automatic add_row(input logic [7:0] c, input logic l, input logic typed,
                           input logic [7:0] b, input logic v, input status_t st);
        stim_row_t row;
        begin
            row.char_val                = c;
            row.last_val                = l;
            row.typed                   = typed;
            row.typed_result.byte_out   = b;
            row.typed_result.byte_valid = v;
            row.typed_result.last_out   = l;
            row.typed_result.status     = st;
            directed_rows.insert(directed_rows.size(), row);
        end
    endtask

    // Sender: directed table first, then random streams, then the final verdict.
    initial
    begin : drive_chars
        logic [7:0] stream[$];
        logic [7:0] c;
        int         kind;
        int         nq;
        int         npad;
        int         p;
        mutation_t  mut;

        push          <= 1'b0;
        char_in       <= '0;
        last_in       <= 1'b0;
        quad_pos      = '0;
        leftover_bits = '0;
        pad_seen      = 1'b0;
        first_error   = ST_OK;
        sent_count    = 0;
        error_count   = 0;

        // A plain quartet decoding to three bytes.
        add_row("T", 1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
        add_row("W", 1'b0, 1'b1, 8'h4D, 1'b1, ST_OK);
        add_row("F", 1'b0, 1'b1, 8'h61, 1'b1, ST_OK);
        add_row("u", 1'b1, 1'b1, 8'h6E, 1'b1, ST_OK);
        // Lowest sextet with double padding.
        add_row("A", 1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
        add_row("A", 1'b0, 1'b1, 8'h00, 1'b1, ST_OK);
        add_row(CH_PAD, 1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
        add_row(CH_PAD, 1'b1, 1'b1, 8'h00, 1'b0, ST_OK);
        // Highest sextets, with nonzero bits discarded before single padding.
        add_row(CH_PLUS, 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row(CH_SLASH, 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row("9", 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row(CH_PAD, 1'b1, 1'b0, '0, 1'b0, ST_OK);
        // Invalid character, then the error sticks to the end of the stream.
        add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_BADCHAR);
        add_row("A", 1'b1, 1'b1, 8'h00, 1'b0, ST_BADCHAR);
        // A byte above the alphabet.
        add_row(8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, ST_BADCHAR);
        // Padding too early in the quartet.
        add_row(CH_PAD, 1'b1, 1'b1, 8'h00, 1'b0, ST_BADPAD);
        add_row("A", 1'b0, 1'b1, 8'h00, 1'b0, ST_OK);
        add_row(CH_PAD, 1'b1, 1'b1, 8'h00, 1'b0, ST_BADPAD);
        // A data character after padding has been accepted.
        add_row("A", 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row("B", 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row(CH_PAD, 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row("C", 1'b1, 1'b0, '0, 1'b0, ST_OK);
        // A stream that ends straight after a single padding character.
        add_row("A", 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row("B", 1'b0, 1'b0, '0, 1'b0, ST_OK);
        add_row(CH_PAD, 1'b1, 1'b0, '0, 1'b0, ST_OK);

        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].char_val, directed_rows[i].last_val,
                      directed_rows[i].typed, directed_rows[i].typed_result);

        // Random streams: mostly well-formed, some damaged, some pure noise.
        while (sent_count < ITEM_TARGET)
        begin
            stream.delete();
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                repeat ($urandom_range(1, 8))
                    stream.insert(stream.size(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                nq = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                 : $urandom_range(1, 3);
                repeat (nq * 4)
                    stream.insert(stream.size(), data_char(6'($urandom_range(0, 63))));
                npad = $urandom_range(0, 2);
                for (int i = 0; i < npad; i++)
                    stream[stream.size() - 1 - i] = CH_PAD;
                if (kind >= 75)
                begin
                    p   = $urandom_range(0, stream.size() - 1);
                    mut = mutation_t'($urandom_range(0, 3));
                    case (mut)
                        MUT_BADCHAR:
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (char_code(c) != CODE_BAD);
                            stream[p] = c;
                        end
                        MUT_EARLY_PAD:
                        begin
                            stream[p] = CH_PAD;
                        end
                        MUT_TRUNCATE:
                        begin
                            repeat ($urandom_range(1, 3)) void'(stream.pop_back());
                        end
                        default:
                        begin
                            stream.insert(stream.size(), data_char(6'($urandom_range(0, 63))));
                        end
                    endcase
                end
            end
            foreach (stream[i])
                send_char(stream[i], i == stream.size() - 1, 1'b0, '0);
        end
        push <= 1'b0;

        // Let every expected result arrive, then allow the pipeline to settle.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: pops in random bursts, with one long hold-off part way through.
    initial
    begin : drive_pop
        bit hold_done;

        hold_done = 1'b0;
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;

        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (byte_out !== want.byte_out)
                begin
                    $error("byte_out: expected %02h, got %02h", want.byte_out, byte_out);
                    error_count++;
                end
                if (byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
                    error_count++;
                end
                if (last_out !== want.last_out)
                begin
                    $error("last_out: expected %0b, got %0b", want.last_out, last_out);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
